@@ rtl/lsrc_pkg.sv @@
// Shared types, constants and divider step functions for the segment clipper.
package lsrc_pkg;

    // Coordinate width and derived arithmetic widths
    localparam int COORD_WIDTH = 24;
    localparam int PROD_W      = 2 * COORD_WIDTH;
    localparam int DIV_BPS     = 3;
    localparam int DIV_QBITS   = ((COORD_WIDTH + DIV_BPS - 1) / DIV_BPS) * DIV_BPS;
    localparam int DIV_STAGES  = DIV_QBITS / DIV_BPS;
    localparam int CFG_IDX_W   = 2;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [COORD_WIDTH:0]   t_wide;

    typedef enum logic [2:0] {
        SIDE_NONE   = 3'd0,
        SIDE_LEFT   = 3'd1,
        SIDE_RIGHT  = 3'd2,
        SIDE_TOP    = 3'd3,
        SIDE_BOTTOM = 3'd4
    } t_side;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RECT_LEFT   = 2'd0,
        CFG_RECT_TOP    = 2'd1,
        CFG_RECT_RIGHT  = 2'd2,
        CFG_RECT_BOTTOM = 2'd3
    } t_cfg_idx;

    localparam t_coord RST_RECT_LEFT   = t_coord'(0);
    localparam t_coord RST_RECT_TOP    = t_coord'(0);
    localparam t_coord RST_RECT_RIGHT  = t_coord'(10000);
    localparam t_coord RST_RECT_BOTTOM = t_coord'(10000);

    typedef struct packed {
        t_coord x1;
        t_coord y1;
        t_coord x2;
        t_coord y2;
    } t_seg;

    // One segment in flight: current and original endpoints, sides, reject
    typedef struct packed {
        logic  rej;
        t_side s1;
        t_side s2;
        t_seg  cur;
        t_seg  org;
    } t_item;

    // Restoring divider state
    typedef struct packed {
        logic [COORD_WIDTH-1:0] rem;
        logic [DIV_QBITS-1:0]   low;
        logic [DIV_QBITS-1:0]   quo;
    } t_div;

    function automatic t_wide ext1(input t_coord c);
        return t_wide'({c[COORD_WIDTH-1], c});
    endfunction

    function automatic logic [COORD_WIDTH-1:0] mag(input t_wide v);
        t_wide n;
        n = -v;
        return v[COORD_WIDTH] ? n[COORD_WIDTH-1:0] : v[COORD_WIDTH-1:0];
    endfunction

    function automatic t_div div_init(input logic [PROD_W-1:0] num);
        t_div r;
        r.rem = COORD_WIDTH'(num >> DIV_QBITS);
        r.low = num[DIV_QBITS-1:0];
        r.quo = '0;
        return r;
    endfunction

    // Retire DIV_BPS quotient bits
    function automatic t_div div_step(input t_div s, input logic [COORD_WIDTH-1:0] den);
        t_div                 r;
        logic [COORD_WIDTH:0] t;
        logic                 qb;
        r = s;
        for (int j = 0; j < DIV_BPS; j++) begin
            t  = {r.rem, r.low[DIV_QBITS-1]};
            qb = (t >= {1'b0, den});
            if (qb) begin
                t = t - {1'b0, den};
            end
            r.rem = t[COORD_WIDTH-1:0];
            r.low = {r.low[DIV_QBITS-2:0], 1'b0};
            r.quo = {r.quo[DIV_QBITS-2:0], qb};
        end
        return r;
    endfunction

endpackage

@@ rtl/lsrc_div.sv @@
// Pipelined unsigned restoring divider, DIV_BPS quotient bits per stage.
module lsrc_div (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [lsrc_pkg::PROD_W-1:0]       i_num,
    input  logic [lsrc_pkg::COORD_WIDTH-1:0]  i_den,
    output logic [lsrc_pkg::COORD_WIDTH-1:0]  o_quo
);
    import lsrc_pkg::*;

    t_div                   r_st  [DIV_STAGES];
    logic [COORD_WIDTH-1:0] r_den [DIV_STAGES];
    t_div                   n_st  [DIV_STAGES];

    // Step each stage from the one before it
    always_comb begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (k == 0) begin
                n_st[k] = div_step(div_init(i_num), i_den);
            end else begin
                n_st[k] = div_step(r_st[k-1], r_den[k-1]);
            end
        end
    end

    // Advance all stages together
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_st[k]  <= n_st[k];
                r_den[k] <= (k == 0) ? i_den : r_den[k-1];
            end
        end
    end

    assign o_quo = r_st[DIV_STAGES-1].quo[COORD_WIDTH-1:0];

endmodule

@@ rtl/lsrc_pass.sv @@
// One clipping pass on one axis: edge test, multiply, divide, endpoint update.
module lsrc_pass (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  lsrc_pkg::t_item  i_item,
    input  logic             i_axis_y,
    input  lsrc_pkg::t_coord i_lo,
    input  lsrc_pkg::t_coord i_hi,
    output logic             o_vld,
    output lsrc_pkg::t_item  o_item
);
    import lsrc_pkg::*;

    typedef struct packed {
        t_item item;
        logic  lo1;
        logic  hi1;
        logic  lo2;
        logic  hi2;
        logic  neg1;
        logic  neg2;
    } t_ctl;

    // Edge test
    t_coord                 u1, u2;
    t_wide                  du, dv, a1w, a2w;
    t_ctl                   n1_ctl;

    always_comb begin
        u1  = i_axis_y ? i_item.cur.y1 : i_item.cur.x1;
        u2  = i_axis_y ? i_item.cur.y2 : i_item.cur.x2;
        du  = i_axis_y ? ext1(i_item.org.y2) - ext1(i_item.org.y1)
                       : ext1(i_item.org.x2) - ext1(i_item.org.x1);
        dv  = i_axis_y ? ext1(i_item.org.x2) - ext1(i_item.org.x1)
                       : ext1(i_item.org.y2) - ext1(i_item.org.y1);
        n1_ctl.item     = i_item;
        n1_ctl.item.rej = i_item.rej || ((u1 < i_lo) && (u2 < i_lo))
                                     || ((u1 > i_hi) && (u2 > i_hi));
        n1_ctl.lo1  = (u1 < i_lo);
        n1_ctl.hi1  = !(u1 < i_lo) && (u1 > i_hi);
        n1_ctl.lo2  = (u2 < i_lo);
        n1_ctl.hi2  = !(u2 < i_lo) && (u2 > i_hi);
        n1_ctl.neg1 = du[COORD_WIDTH] ^ dv[COORD_WIDTH] ^ n1_ctl.hi1;
        n1_ctl.neg2 = du[COORD_WIDTH] ^ dv[COORD_WIDTH] ^ n1_ctl.hi2;
        a1w = n1_ctl.lo1 ? ext1(i_lo) - ext1(u1) : ext1(u1) - ext1(i_hi);
        a2w = n1_ctl.lo2 ? ext1(i_lo) - ext1(u2) : ext1(u2) - ext1(i_hi);
    end

    logic                   r1_vld;
    t_ctl                   r1_ctl;
    logic [COORD_WIDTH-1:0] r1_a1, r1_a2, r1_mdu, r1_mdv;

    logic                   r2_vld;
    t_ctl                   r2_ctl;
    logic [PROD_W-1:0]      r2_p1, r2_p2;
    logic [COORD_WIDTH-1:0] r2_den;

    logic                   r_dl_vld [DIV_STAGES];
    t_ctl                   r_dl_ctl [DIV_STAGES];

    logic                   r3_vld;
    t_item                  r3_item;

    t_ctl   c3;
    t_item  n3_item;
    t_coord t1, t2, v1, v2, e1, e2;
    t_side  sl, sh;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_dl_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_dl_vld[k] <= (k == 0) ? r2_vld : r_dl_vld[k-1];
            end
            r3_vld <= r_dl_vld[DIV_STAGES-1];
        end
    end

    // Payload: test, multiply, carry alongside the divider
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ctl <= n1_ctl;
            r1_a1  <= a1w[COORD_WIDTH-1:0];
            r1_a2  <= a2w[COORD_WIDTH-1:0];
            r1_mdu <= mag(du);
            r1_mdv <= mag(dv);
            r2_ctl <= r1_ctl;
            r2_p1  <= PROD_W'(r1_mdv) * PROD_W'(r1_a1);
            r2_p2  <= PROD_W'(r1_mdv) * PROD_W'(r1_a2);
            r2_den <= r1_mdu;
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_dl_ctl[k] <= (k == 0) ? r2_ctl : r_dl_ctl[k-1];
            end
            r3_item <= n3_item;
        end
    end

    logic [COORD_WIDTH-1:0] q1, q2;

    lsrc_div u_div1 (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num (r2_p1),
        .i_den (r2_den),
        .o_quo (q1)
    );

    lsrc_div u_div2 (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num (r2_p2),
        .i_den (r2_den),
        .o_quo (q2)
    );

    // Move cut endpoints onto the edge and shift the other coordinate
    always_comb begin
        c3      = r_dl_ctl[DIV_STAGES-1];
        n3_item = c3.item;
        t1      = c3.neg1 ? -t_coord'(q1) : t_coord'(q1);
        t2      = c3.neg2 ? -t_coord'(q2) : t_coord'(q2);
        v1      = (i_axis_y ? c3.item.cur.x1 : c3.item.cur.y1) + t1;
        v2      = (i_axis_y ? c3.item.cur.x2 : c3.item.cur.y2) + t2;
        e1      = c3.lo1 ? i_lo : i_hi;
        e2      = c3.lo2 ? i_lo : i_hi;
        sl      = i_axis_y ? SIDE_TOP : SIDE_LEFT;
        sh      = i_axis_y ? SIDE_BOTTOM : SIDE_RIGHT;
        if (!c3.item.rej) begin
            if (c3.lo1 || c3.hi1) begin
                n3_item.s1 = c3.lo1 ? sl : sh;
                if (i_axis_y) begin
                    n3_item.cur.y1 = e1;
                    n3_item.cur.x1 = v1;
                end else begin
                    n3_item.cur.x1 = e1;
                    n3_item.cur.y1 = v1;
                end
            end
            if (c3.lo2 || c3.hi2) begin
                n3_item.s2 = c3.lo2 ? sl : sh;
                if (i_axis_y) begin
                    n3_item.cur.y2 = e2;
                    n3_item.cur.x2 = v2;
                end else begin
                    n3_item.cur.x2 = e2;
                    n3_item.cur.y2 = v2;
                end
            end
        end
    end

    assign o_vld  = r3_vld;
    assign o_item = r3_item;

endmodule

@@ rtl/line_segment_rect_clipper.sv @@
// Top level of the pipelined two-pass rectangle clipper for line segments.
//
//   channel   direction  handshake              payload
//   input     in         i_valid / o_ready      i_start_x i_start_y i_end_x i_end_y
//   result    out        o_valid / i_ready      o_visible o_clipped_* o_start_side o_end_side
//   config    in         i_cfg_we               i_cfg_idx i_cfg_data
//
// One segment per cycle sustained while the skid stage is empty. Latency is dominated by the
// two divider chains, one per pass, at DIV_BPS quotient bits a stage.
// Reset is synchronous, active low; it empties the pipeline and loads the default
// rectangle. The whole pipeline holds while the skid stage is full; o_ready is
// registered and drops only then.
module line_segment_rect_clipper (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  lsrc_pkg::t_coord                 i_start_x,
    input  lsrc_pkg::t_coord                 i_start_y,
    input  lsrc_pkg::t_coord                 i_end_x,
    input  lsrc_pkg::t_coord                 i_end_y,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic                             o_visible,
    output lsrc_pkg::t_coord                 o_clipped_start_x,
    output lsrc_pkg::t_coord                 o_clipped_start_y,
    output lsrc_pkg::t_coord                 o_clipped_end_x,
    output lsrc_pkg::t_coord                 o_clipped_end_y,
    output logic [2:0]                       o_start_side,
    output logic [2:0]                       o_end_side,
    input  logic                             i_cfg_we,
    input  logic [lsrc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lsrc_pkg::COORD_WIDTH-1:0] i_cfg_data
);
    import lsrc_pkg::*;

    t_coord r_rect_left, r_rect_top, r_rect_right, r_rect_bottom;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rect_left   <= RST_RECT_LEFT;
            r_rect_top    <= RST_RECT_TOP;
            r_rect_right  <= RST_RECT_RIGHT;
            r_rect_bottom <= RST_RECT_BOTTOM;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_RECT_LEFT:   r_rect_left   <= t_coord'(i_cfg_data);
                CFG_RECT_TOP:    r_rect_top    <= t_coord'(i_cfg_data);
                CFG_RECT_RIGHT:  r_rect_right  <= t_coord'(i_cfg_data);
                CFG_RECT_BOTTOM: r_rect_bottom <= t_coord'(i_cfg_data);
                default: ;
            endcase
        end
    end

    logic  en;
    logic  r_skid_vld, r_out_vld;
    t_item r_skid, r_out;

    assign en      = !r_skid_vld;
    assign o_ready = en;

    // Input register; reject at once when both ends lie beyond one y edge
    t_item n0_item;
    logic  r0_vld;
    t_item r0_item;

    always_comb begin
        n0_item.org.x1 = i_start_x;
        n0_item.org.y1 = i_start_y;
        n0_item.org.x2 = i_end_x;
        n0_item.org.y2 = i_end_y;
        n0_item.cur    = n0_item.org;
        n0_item.s1     = SIDE_NONE;
        n0_item.s2     = SIDE_NONE;
        n0_item.rej    = ((i_start_y < r_rect_top) && (i_end_y < r_rect_top))
                      || ((i_start_y > r_rect_bottom) && (i_end_y > r_rect_bottom));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (en) begin
            r0_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_item <= n0_item;
        end
    end

    logic  px_vld, py_vld;
    t_item px_item, py_item;

    lsrc_pass u_pass_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_vld    (r0_vld),
        .i_item   (r0_item),
        .i_axis_y (1'b0),
        .i_lo     (r_rect_left),
        .i_hi     (r_rect_right),
        .o_vld    (px_vld),
        .o_item   (px_item)
    );

    lsrc_pass u_pass_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_vld    (px_vld),
        .i_item   (px_item),
        .i_axis_y (1'b1),
        .i_lo     (r_rect_top),
        .i_hi     (r_rect_bottom),
        .o_vld    (py_vld),
        .o_item   (py_item)
    );

    // Output register with skid stage
    logic take;
    assign take = en && py_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || i_ready) begin
            r_out_vld  <= r_skid_vld || take;
            r_skid_vld <= 1'b0;
        end else if (take) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || i_ready) begin
            r_out <= r_skid_vld ? r_skid : py_item;
        end else if (take) begin
            r_skid <= py_item;
        end
    end

    // Rejected beats return the original endpoints
    assign o_valid           = r_out_vld;
    assign o_visible         = !r_out.rej;
    assign o_clipped_start_x = r_out.rej ? r_out.org.x1 : r_out.cur.x1;
    assign o_clipped_start_y = r_out.rej ? r_out.org.y1 : r_out.cur.y1;
    assign o_clipped_end_x   = r_out.rej ? r_out.org.x2 : r_out.cur.x2;
    assign o_clipped_end_y   = r_out.rej ? r_out.org.y2 : r_out.cur.y2;
    assign o_start_side      = r_out.s1;
    assign o_end_side        = r_out.s2;

endmodule

@@ rtl/lsrc_chk.sv @@
// Port-level checker for the segment clipper, bound to the top level.
module lsrc_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_ready,
    input logic                             o_valid,
    input logic                             i_ready,
    input logic                             o_visible,
    input lsrc_pkg::t_coord                 o_clipped_start_x,
    input lsrc_pkg::t_coord                 o_clipped_start_y,
    input lsrc_pkg::t_coord                 o_clipped_end_x,
    input lsrc_pkg::t_coord                 o_clipped_end_y,
    input logic [2:0]                       o_start_side,
    input logic [2:0]                       o_end_side,
    input logic                             i_cfg_we,
    input logic [lsrc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input logic [lsrc_pkg::COORD_WIDTH-1:0] i_cfg_data
);
    import lsrc_pkg::*;

    t_coord r_left, r_top, r_right, r_bottom;

    // Shadow the rectangle from the write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= RST_RECT_LEFT;
            r_top    <= RST_RECT_TOP;
            r_right  <= RST_RECT_RIGHT;
            r_bottom <= RST_RECT_BOTTOM;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_RECT_LEFT:   r_left   <= t_coord'(i_cfg_data);
                CFG_RECT_TOP:    r_top    <= t_coord'(i_cfg_data);
                CFG_RECT_RIGHT:  r_right  <= t_coord'(i_cfg_data);
                CFG_RECT_BOTTOM: r_bottom <= t_coord'(i_cfg_data);
                default: ;
            endcase
        end
    end

    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid && o_ready)
        else $error("result valid or input stalled right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_clipped_start_x)
            && $stable(o_clipped_end_y) && $stable(o_visible))
        else $error("stalled result beat changed");

    a_x_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_visible |->
            (o_start_side != SIDE_LEFT   || o_clipped_start_x == r_left)
         && (o_start_side != SIDE_RIGHT  || o_clipped_start_x == r_right)
         && (o_end_side   != SIDE_LEFT   || o_clipped_end_x   == r_left)
         && (o_end_side   != SIDE_RIGHT  || o_clipped_end_x   == r_right))
        else $error("x cut endpoint not on its edge");

    a_y_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_visible |->
            (o_start_side != SIDE_TOP    || o_clipped_start_y == r_top)
         && (o_start_side != SIDE_BOTTOM || o_clipped_start_y == r_bottom)
         && (o_end_side   != SIDE_TOP    || o_clipped_end_y   == r_top)
         && (o_end_side   != SIDE_BOTTOM || o_clipped_end_y   == r_bottom))
        else $error("y cut endpoint not on its edge");

endmodule

bind line_segment_rect_clipper lsrc_chk u_lsrc_chk (.*);
